[rtl/core/dwes_pkg.sv]
// Package: shared types, commands and constants of the wave elevation sum block.
`timescale 1ns / 1ps

package dwes_pkg;

	localparam int unsigned MAX_COMPONENTS_DEF = 1024;
	localparam int unsigned ANGLE_BITS_DEF     = 16;

	localparam int unsigned ACTIVE_W = 11;
	localparam int unsigned IDX_W    = 10;
	localparam int unsigned DATA_W   = 32;
	localparam int unsigned TURN_W   = 16;
	localparam int unsigned ELEV_W   = 48;

	localparam logic [ACTIVE_W-1:0] ACTIVE_RST = 11'd1024;

	// request function codes
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// angle source for a cosine evaluation
	localparam logic [1:0] ANG_DCOS  = 2'd0;
	localparam logic [1:0] ANG_DSIN  = 2'd1;
	localparam logic [1:0] ANG_PHASE = 2'd2;

	// partial product of a 56-bit modular product (low/high 28-bit halves)
	localparam logic [1:0] PV_LL = 2'd0;
	localparam logic [1:0] PV_HL = 2'd1;
	localparam logic [1:0] PV_LH = 2'd2;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_RD,
		OP_CSET,
		OP_MZZ,
		OP_Z2,
		OP_MPZ,
		OP_PUP,
		OP_FIN,
		OP_SAVE,
		OP_MXC,
		OP_ACCX,
		OP_MYS,
		OP_PROJ,
		OP_MK,
		OP_KT,
		OP_MW,
		OP_WT,
		OP_MPH,
		OP_PAC,
		OP_MA,
		OP_ACC,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [2:0] coef;
		logic [1:0] sel;
		logic       neg;
	} dp_cmd_t;

	typedef struct packed {
		logic last;
		logic zero;
	} dp_stat_t;

endpackage

[rtl/core/dwes_if.sv]
// Interfaces: request and response channels of the wave elevation sum block.
`timescale 1ns / 1ps

interface dwes_req_if;
	logic                valid;
	logic                ready;
	logic                func;
	logic [9:0]          entry_index;
	logic signed [31:0]  amplitude;
	logic signed [31:0]  wavenumber;
	logic signed [31:0]  angular_freq;
	logic [15:0]         phase_offset;
	logic [15:0]         direction;
	logic signed [31:0]  x_pos;
	logic signed [31:0]  y_pos;
	logic signed [31:0]  time_val;

	modport source (
		output valid, func, entry_index, amplitude, wavenumber, angular_freq,
		       phase_offset, direction, x_pos, y_pos, time_val,
		input  ready
	);
	modport sink (
		input  valid, func, entry_index, amplitude, wavenumber, angular_freq,
		       phase_offset, direction, x_pos, y_pos, time_val,
		output ready
	);
endinterface

interface dwes_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [47:0] elevation;

	modport source (output valid, elevation, input ready);
	modport sink (input valid, elevation, output ready);
endinterface

[rtl/core/dwes_ctrl.sv]
// Controller: sequences the per-component evaluation steps of a query.
`timescale 1ns / 1ps

module dwes_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_func,
	output logic               req_ready,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	input  dwes_pkg::dp_stat_t stat,
	output dwes_pkg::dp_cmd_t  cmd
);

	typedef enum logic [4:0] {
		S_IDLE, S_RD, S_CSET, S_MZZ, S_Z2, S_MPZ, S_PUP, S_FIN, S_SAVE,
		S_MXC, S_ACCX, S_MYS, S_PROJ, S_MK, S_KT, S_MW, S_WT,
		S_MPH, S_PAC, S_MA, S_ACC, S_EMIT
	} state_t;

	state_t     state_q;
	logic [1:0] ang_q;
	logic [2:0] hk_q;
	logic [2:0] pj_q;
	logic       rsp_valid_q;
	logic       slot_free;
	logic       pj_hi;
	logic [1:0] pj_var;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign slot_free = !rsp_valid_q || rsp_ready;

	// split the phase step count into product pair and partial product
	assign pj_hi  = (pj_q >= 3'd3);
	assign pj_var = pj_hi ? 2'(pj_q - 3'd3) : pj_q[1:0];

	// decode state into a datapath command
	always_comb begin
		cmd      = '0;
		cmd.op   = dwes_pkg::OP_NONE;
		cmd.coef = hk_q;
		cmd.sel  = ang_q;
		case (state_q)
			S_RD:   cmd.op = dwes_pkg::OP_RD;
			S_CSET: cmd.op = dwes_pkg::OP_CSET;
			S_MZZ:  cmd.op = dwes_pkg::OP_MZZ;
			S_Z2:   cmd.op = dwes_pkg::OP_Z2;
			S_MPZ:  cmd.op = dwes_pkg::OP_MPZ;
			S_PUP:  cmd.op = dwes_pkg::OP_PUP;
			S_FIN:  cmd.op = dwes_pkg::OP_FIN;
			S_SAVE: cmd.op = dwes_pkg::OP_SAVE;
			S_MXC:  cmd.op = dwes_pkg::OP_MXC;
			S_ACCX: cmd.op = dwes_pkg::OP_ACCX;
			S_MYS:  cmd.op = dwes_pkg::OP_MYS;
			S_PROJ: cmd.op = dwes_pkg::OP_PROJ;
			S_MK:   cmd.op = dwes_pkg::OP_MK;
			S_KT:   cmd.op = dwes_pkg::OP_KT;
			S_MW:   cmd.op = dwes_pkg::OP_MW;
			S_WT:   cmd.op = dwes_pkg::OP_WT;
			S_MPH: begin
				cmd.op  = dwes_pkg::OP_MPH;
				cmd.sel = pj_var;
				cmd.neg = pj_hi;
			end
			S_PAC: begin
				cmd.op  = dwes_pkg::OP_PAC;
				cmd.sel = pj_var;
				cmd.neg = pj_hi;
			end
			S_MA:   cmd.op = dwes_pkg::OP_MA;
			S_ACC:  cmd.op = dwes_pkg::OP_ACC;
			S_EMIT: cmd.op = slot_free ? dwes_pkg::OP_EMIT : dwes_pkg::OP_NONE;
			default: cmd.op = dwes_pkg::OP_NONE;
		endcase
	end

	// advance state and hold the response valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ang_q       <= dwes_pkg::ANG_DCOS;
			hk_q        <= '0;
			pj_q        <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid && req_func == dwes_pkg::FUNC_QUERY) begin
						state_q <= stat.zero ? S_EMIT : S_RD;
					end
				end
				S_RD: begin
					ang_q   <= dwes_pkg::ANG_DCOS;
					state_q <= S_CSET;
				end
				S_CSET: state_q <= S_MZZ;
				S_MZZ:  state_q <= S_Z2;
				S_Z2: begin
					hk_q    <= 3'd5;
					state_q <= S_MPZ;
				end
				S_MPZ:  state_q <= (hk_q == 3'd0) ? S_FIN : S_PUP;
				S_PUP: begin
					hk_q    <= hk_q - 3'd1;
					state_q <= S_MPZ;
				end
				S_FIN: begin
					case (ang_q)
						dwes_pkg::ANG_DCOS: state_q <= S_SAVE;
						dwes_pkg::ANG_DSIN: state_q <= S_MXC;
						default:            state_q <= S_MA;
					endcase
				end
				S_SAVE: begin
					ang_q   <= dwes_pkg::ANG_DSIN;
					state_q <= S_CSET;
				end
				S_MXC:  state_q <= S_ACCX;
				S_ACCX: state_q <= S_MYS;
				S_MYS:  state_q <= S_PROJ;
				S_PROJ: state_q <= S_MK;
				S_MK:   state_q <= S_KT;
				S_KT:   state_q <= S_MW;
				S_MW:   state_q <= S_WT;
				S_WT: begin
					pj_q    <= '0;
					state_q <= S_MPH;
				end
				S_MPH:  state_q <= S_PAC;
				S_PAC: begin
					if (pj_q == 3'd5) begin
						ang_q   <= dwes_pkg::ANG_PHASE;
						state_q <= S_CSET;
					end else begin
						pj_q    <= pj_q + 3'd1;
						state_q <= S_MPH;
					end
				end
				S_MA:   state_q <= S_ACC;
				S_ACC:  state_q <= stat.last ? S_EMIT : S_RD;
				S_EMIT: begin
					if (slot_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[rtl/core/dwes_dpath.sv]
// Datapath: component table, shared multiplier, cosine and phase arithmetic.
`timescale 1ns / 1ps

module dwes_dpath #(
	parameter int unsigned MAX_COMPONENTS = dwes_pkg::MAX_COMPONENTS_DEF,
	parameter int unsigned ANGLE_BITS     = dwes_pkg::ANGLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  dwes_pkg::dp_cmd_t                 cmd,
	output dwes_pkg::dp_stat_t                stat,
	input  logic                              req_accept,
	input  logic                              req_func,
	input  logic [dwes_pkg::IDX_W-1:0]        entry_index,
	input  logic signed [31:0]                amplitude,
	input  logic signed [31:0]                wavenumber,
	input  logic signed [31:0]                angular_freq,
	input  logic [15:0]                       phase_offset,
	input  logic [15:0]                       direction,
	input  logic signed [31:0]                x_pos,
	input  logic signed [31:0]                y_pos,
	input  logic signed [31:0]                time_val,
	input  logic                              cfg_wr_en,
	input  logic [dwes_pkg::ACTIVE_W-1:0]     cfg_wr_data,
	output logic signed [dwes_pkg::ELEV_W-1:0] elevation
);

	localparam int unsigned ADDR_W = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
	localparam logic [31:0] ANG_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
	localparam logic [31:0] QUARTER  = 32'h4000_0000;
	localparam logic [31:0] INV_2PI  = 32'd683565276;
	localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
	localparam logic signed [49:0] SUM_MAX = 50'sd140737488355327;
	localparam logic signed [49:0] SUM_MIN = -50'sd140737488355328;

	typedef struct packed {
		logic [31:0] amp;
		logic [31:0] k;
		logic [31:0] w;
		logic [15:0] ph;
		logic [15:0] dir;
	} entry_t;

	entry_t                  mem_q [MAX_COMPONENTS];
	entry_t                  rd_q;
	logic [dwes_pkg::ACTIVE_W-1:0] active_q;
	logic [ADDR_W-1:0]       n_q;
	logic signed [31:0]      x_q, y_q, t_q;
	logic [30:0]             zq_q, z2_q, p_q;
	logic                    neg_q;
	logic signed [31:0]      cres_q, cd_q;
	logic signed [63:0]      pacc_q;
	logic signed [33:0]      proj_q;
	logic signed [46:0]      kt_q, wt_q;
	logic [55:0]             ph_q;
	logic signed [47:0]      acc_q, elev_q;
	logic signed [65:0]      mul_q;

	logic signed [32:0]      ma, mb;
	logic [31:0]             cnt32;
	logic [31:0]             ang, u;
	logic [30:0]             z, zc;
	logic [31:0]             sh30;
	logic signed [32:0]      r;
	logic [30:0]             rc;
	logic signed [31:0]      rpos;
	logic signed [63:0]      psum;
	logic [55:0]             pa, pb, prod, addend;
	logic [27:0]             ha, hb;
	logic signed [32:0]      term;
	logic signed [49:0]      asum;

	function automatic logic [30:0] cos_coef(input logic [2:0] idx);
		logic [30:0] c;
		case (idx)
			3'd1:    c = 31'd1324675879;
			3'd2:    c = 31'd272375560;
			3'd3:    c = 31'd22401992;
			3'd4:    c = 31'd987048;
			3'd5:    c = 31'd27060;
			3'd6:    c = 31'd506;
			default: c = Q30_ONE;
		endcase
		return c;
	endfunction

	// clamp the count to the table depth
	always_comb begin
		cnt32 = (32'(active_q) > MAX_COMPONENTS) ? MAX_COMPONENTS : 32'(active_q);
	end
	assign stat.zero = (cnt32 == 32'd0);
	assign stat.last = (32'(n_q) == cnt32 - 32'd1);
	assign elevation = elev_q;

	// select the angle and fold it into the first quadrant
	always_comb begin
		case (cmd.sel)
			dwes_pkg::ANG_DCOS: ang = {rd_q.dir, 16'h0000};
			dwes_pkg::ANG_DSIN: ang = {rd_q.dir, 16'h0000} - QUARTER;
			default:            ang = ph_q[55:24];
		endcase
		u  = ang & ANG_MASK;
		z  = {1'b0, u[29:0]};
		zc = Q30_ONE - z;
	end

	// form the operands of the modular phase product
	always_comb begin
		pa = cmd.neg ? 56'(wt_q) : 56'(kt_q);
		pb = cmd.neg ? 56'(t_q) : 56'(proj_q);
		case (cmd.sel)
			dwes_pkg::PV_HL: begin
				ha = pa[55:28];
				hb = pb[27:0];
			end
			dwes_pkg::PV_LH: begin
				ha = pa[27:0];
				hb = pb[55:28];
			end
			default: begin
				ha = pa[27:0];
				hb = pb[27:0];
			end
		endcase
	end

	// route the shared multiplier operands
	always_comb begin
		case (cmd.op)
			dwes_pkg::OP_MZZ: begin
				ma = {2'b00, zq_q};
				mb = {2'b00, zq_q};
			end
			dwes_pkg::OP_MPZ: begin
				ma = {2'b00, p_q};
				mb = {2'b00, z2_q};
			end
			dwes_pkg::OP_MXC: begin
				ma = 33'(x_q);
				mb = 33'(cd_q);
			end
			dwes_pkg::OP_MYS: begin
				ma = 33'(y_q);
				mb = 33'(cres_q);
			end
			dwes_pkg::OP_MK: begin
				ma = 33'($signed(rd_q.k));
				mb = {1'b0, INV_2PI};
			end
			dwes_pkg::OP_MW: begin
				ma = 33'($signed(rd_q.w));
				mb = {1'b0, INV_2PI};
			end
			dwes_pkg::OP_MPH: begin
				ma = {5'b00000, ha};
				mb = {5'b00000, hb};
			end
			dwes_pkg::OP_MA: begin
				ma = 33'($signed(rd_q.amp));
				mb = 33'(cres_q);
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	// combine multiplier results
	always_comb begin
		sh30   = mul_q[61:30];
		r      = $signed({2'b00, Q30_ONE}) - $signed({1'b0, sh30});
		rc     = r[32] ? 31'd0 : r[30:0];
		rpos   = $signed({1'b0, rc});
		psum   = pacc_q + mul_q[63:0];
		prod   = mul_q[55:0];
		addend = (cmd.sel != dwes_pkg::PV_LL) ? {prod[27:0], 28'h0} : prod;
		term   = mul_q[62:30];
		asum   = 50'(acc_q) + 50'(term);
	end

	// write loads, read the entry under evaluation
	always_ff @(posedge clk) begin
		if (req_accept && req_func == dwes_pkg::FUNC_LOAD &&
		    32'(entry_index) < MAX_COMPONENTS) begin
			mem_q[ADDR_W'(entry_index)] <= {amplitude, wavenumber, angular_freq,
			                                phase_offset, direction};
		end
		if (cmd.op == dwes_pkg::OP_RD) begin
			rd_q <= mem_q[n_q];
		end
	end

	// hold the active count and the entry index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= dwes_pkg::ACTIVE_RST;
			n_q      <= '0;
		end else begin
			if (cfg_wr_en) begin
				active_q <= cfg_wr_data;
			end
			if (req_accept && req_func == dwes_pkg::FUNC_QUERY) begin
				n_q <= '0;
			end else if (cmd.op == dwes_pkg::OP_ACC) begin
				n_q <= n_q + 1'b1;
			end
		end
	end

	// run the datapath step given by the command
	always_ff @(posedge clk) begin
		mul_q <= ma * mb;
		if (req_accept && req_func == dwes_pkg::FUNC_QUERY) begin
			x_q   <= x_pos;
			y_q   <= y_pos;
			t_q   <= time_val;
			acc_q <= '0;
		end
		case (cmd.op)
			dwes_pkg::OP_CSET: begin
				zq_q  <= u[30] ? zc : z;
				neg_q <= u[31] ^ u[30];
			end
			dwes_pkg::OP_Z2: begin
				z2_q <= mul_q[60:30];
				p_q  <= cos_coef(3'd6);
			end
			dwes_pkg::OP_PUP:  p_q <= 31'({1'b0, cos_coef(cmd.coef)} - sh30);
			dwes_pkg::OP_FIN:  cres_q <= neg_q ? -rpos : rpos;
			dwes_pkg::OP_SAVE: cd_q <= cres_q;
			dwes_pkg::OP_ACCX: pacc_q <= mul_q[63:0];
			dwes_pkg::OP_PROJ: proj_q <= psum[63:30];
			dwes_pkg::OP_KT: begin
				kt_q <= mul_q[62:16];
				ph_q <= {rd_q.ph, 40'h0};
			end
			dwes_pkg::OP_WT:   wt_q <= mul_q[62:16];
			dwes_pkg::OP_PAC:  ph_q <= cmd.neg ? ph_q - addend : ph_q + addend;
			dwes_pkg::OP_ACC: begin
				if (asum > SUM_MAX) begin
					acc_q <= SUM_MAX[47:0];
				end else if (asum < SUM_MIN) begin
					acc_q <= SUM_MIN[47:0];
				end else begin
					acc_q <= asum[47:0];
				end
			end
			dwes_pkg::OP_EMIT: elev_q <= acc_q;
			default: ;
		endcase
	end

endmodule

[rtl/core/directional_wave_elevation_sum.sv]
// Top level: directional sum-of-sinusoids elevation block.
// A load request writes the table when its index is in range; the block stays ready
// for the next request. A query evaluates each summed component with one shared
// multiplier and three cosine evaluations; a zero count goes straight to the response.
// A new request is taken only in idle, after a query has placed its response, which
// waits in an output register. Reset clears control and sets the count to 1024; the
// table is undefined.
`timescale 1ns / 1ps

module directional_wave_elevation_sum #(
	parameter int unsigned MAX_COMPONENTS = dwes_pkg::MAX_COMPONENTS_DEF,
	parameter int unsigned ANGLE_BITS     = dwes_pkg::ANGLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	dwes_req_if.sink                      req,
	dwes_rsp_if.source                    rsp,
	input  logic                          cfg_wr_en,
	input  logic [dwes_pkg::ACTIVE_W-1:0] cfg_wr_data
);

	dwes_pkg::dp_cmd_t  cmd;
	dwes_pkg::dp_stat_t stat;
	logic               req_accept;

	assign req_accept = req.valid && req.ready;

	dwes_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_func  (req.func),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	dwes_dpath #(
		.MAX_COMPONENTS (MAX_COMPONENTS),
		.ANGLE_BITS     (ANGLE_BITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.req_accept   (req_accept),
		.req_func     (req.func),
		.entry_index  (req.entry_index),
		.amplitude    (req.amplitude),
		.wavenumber   (req.wavenumber),
		.angular_freq (req.angular_freq),
		.phase_offset (req.phase_offset),
		.direction    (req.direction),
		.x_pos        (req.x_pos),
		.y_pos        (req.y_pos),
		.time_val     (req.time_val),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.elevation    (rsp.elevation)
	);

endmodule

[rtl/core/dwes_checker.sv]
// Checker: port-level properties of the wave elevation sum block, with its bind.
`timescale 1ns / 1ps

module dwes_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        req_func,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [47:0] rsp_elevation
);

	// hold a stalled response
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_elevation))
		else $error("response changed while stalled");

	// drop ready only after a query request
	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(req_ready) |-> $past(req_valid && req_ready && req_func))
		else $error("ready fell without a query request");

	// keep ready after a load request
	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && !req_func |=> req_ready)
		else $error("load request stalled the block");

	// raise a response only at the end of a query
	a_rsp_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!req_ready))
		else $error("response without a query in progress");

endmodule

bind directional_wave_elevation_sum dwes_checker u_dwes_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.req_func      (req.func),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_elevation (rsp.elevation)
);
